FILE: hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: hdl/rbol_pkg.sv
package rbol_pkg;

   localparam int DRAW_BITS  = 16;
   localparam int KEY_W      = 48;
   localparam int ENT_W      = 32;
   localparam int STATUS_W   = 3;
   localparam int TOTAL_W    = 7;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 40;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_REMOVED  = 3'd1,
      ST_CLEARED  = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_FULL     = 3'd4
   } rbol_status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_SRCH_ADDR, S_SRCH_CMP, S_INS_NEW, S_INS_KEY, S_INS_WR,
      S_DIV_B, S_RD_FILL, S_RD_FILLW, S_DIV_E, S_PICK_A, S_PICK_D, S_TAIL_D,
      S_MV_ADDR, S_MV_KEY, S_CP_ADDR, S_CP_WR, S_FINISH
   } rbol_state_type;

   typedef enum logic [1:0] {TB_HOLD, TB_IDX, TB_COUNT, TB_DIV} rbol_tb_sel_type;
   typedef enum logic [1:0] {KF_IDX, KF_TB, KF_LAST} rbol_kf_sel_type;
   typedef enum logic [1:0] {RD_PICK, RD_TAIL, RD_COPY} rbol_rd_sel_type;
   typedef enum logic [1:0] {WR_FILL, WR_PICK, WR_COPY} rbol_wr_sel_type;
   typedef enum logic {DIV_BUCKET, DIV_ENTRY} rbol_div_sel_type;
   typedef enum logic {KEY_REQ, KEY_RD} rbol_key_src_type;
   typedef enum logic [1:0] {FILL_INC, FILL_DEC, FILL_RD} rbol_fill_src_type;
   typedef enum logic {ENT_REQ, ENT_RD} rbol_ent_src_type;

   typedef struct packed {
      logic              load_req;
      logic              count_clr;
      logic              count_inc;
      logic              count_dec;
      logic              idx_clr;
      logic              idx_inc;
      rbol_tb_sel_type   tb_sel;
      logic              p_ld;
      logic              fill_cap;
      logic              fill_zero;
      logic              cpy_clr;
      logic              cpy_inc;
      logic              got_cap;
      logic              div_start;
      rbol_div_sel_type  div_sel;
      rbol_kf_sel_type   kf_sel;
      rbol_rd_sel_type   rd_sel;
      logic              key_wr;
      rbol_key_src_type  key_src;
      logic              fill_wr;
      rbol_fill_src_type fill_src;
      logic              ent_wr;
      rbol_wr_sel_type   wr_sel;
      rbol_ent_src_type  ent_src;
      logic              res_load;
      rbol_status_type   res_status;
   } rbol_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       count_zero;
      logic       count_full;
      logic       idx_eq_count;
      logic       key_match;
      logic       fill_rd_full;
      logic       div_done;
      logic       fill_one;
      logic       tb_is_last;
      logic       copy_done;
      logic       out_free;
   } rbol_stat_type;

endpackage

FILE: hdl/rbol_mod.sv
module rbol_mod import rbol_pkg::*; #(
   parameter int DVW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DRAW_BITS-1:0] dividend,
   input  logic [DVW-1:0]       divisor,
   output logic                 done,
   output logic [DVW-1:0]       remainder
);

   localparam int CNTW = $clog2(DRAW_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [DRAW_BITS-1:0] dvd_ff, dvd_in;
   logic [DVW-1:0]       dsr_ff, dsr_in;
   logic [DVW-1:0]       rem_ff, rem_in;
   logic [DVW:0]         trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[DRAW_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(DRAW_BITS);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DRAW_BITS-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DVW'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = DVW'(trial);
         end
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/rbol_dp.sv
module rbol_dp import rbol_pkg::*; #(
   parameter int MAX_BUCKETS  = 64,
   parameter int BUCKET_DEPTH = 64,
   parameter int KEY_BITS     = 48,
   parameter int ENTRY_BITS   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rbol_cmd_type          cmd,
   output rbol_stat_type         stat,
   input  logic [1:0]            req_op,
   input  logic [KEY_W-1:0]      req_key,
   input  logic [ENT_W-1:0]      req_ent,
   input  logic [DRAW_BITS-1:0]  req_bdraw,
   input  logic [DRAW_BITS-1:0]  req_edraw,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ENT_W-1:0]      rsp_entry,
   output logic                  rsp_empty,
   output logic [TOTAL_W-1:0]    rsp_total
);

   localparam int BW  = $clog2(MAX_BUCKETS);
   localparam int CW  = $clog2(MAX_BUCKETS + 1);
   localparam int SW  = $clog2(BUCKET_DEPTH);
   localparam int FW  = $clog2(BUCKET_DEPTH + 1);
   localparam int SD  = MAX_BUCKETS * BUCKET_DEPTH;
   localparam int AW  = $clog2(SD);
   localparam int DVW = (CW > FW) ? CW : FW;

   logic [KEY_BITS-1:0]   key_mem [MAX_BUCKETS];
   logic [FW-1:0]         fill_mem [MAX_BUCKETS];
   logic [ENTRY_BITS-1:0] ent_mem [SD];

   logic [1:0]            op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [ENTRY_BITS-1:0] ent_ff;
   logic [DRAW_BITS-1:0]  bd_ff, ed_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [BW-1:0]         tb_ff, tb_in;
   logic [SW-1:0]         p_ff;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [FW-1:0]         cpy_ff, cpy_in;
   logic [ENTRY_BITS-1:0] got_ff;
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [FW-1:0]         fill_rd_ff;
   logic [ENTRY_BITS-1:0] ent_rd_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [ENT_W-1:0]      rsp_entry_ff;
   logic                  rsp_empty_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;

   logic [BW-1:0]         last;
   logic [BW-1:0]         kf_addr;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [KEY_BITS-1:0]   key_wdata;
   logic [FW-1:0]         fill_wdata;
   logic [ENTRY_BITS-1:0] ent_wdata;
   logic [DRAW_BITS-1:0]  div_dvd;
   logic [DVW-1:0]        div_dsr, div_rem;
   logic                  div_done;

   function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b,
                                                input logic [FW-1:0] s);
      slot_addr = AW'(AW'(b) * AW'(BUCKET_DEPTH) + AW'(s));
   endfunction

   assign last = BW'(count_ff - CW'(1));

   always_comb begin
      case (cmd.kf_sel)
         KF_IDX:  kf_addr = BW'(idx_ff);
         KF_TB:   kf_addr = tb_ff;
         default: kf_addr = last;
      endcase
      case (cmd.rd_sel)
         RD_PICK: rd_addr = slot_addr(tb_ff, FW'(p_ff));
         RD_TAIL: rd_addr = slot_addr(tb_ff, fill_ff - FW'(1));
         default: rd_addr = slot_addr(last, cpy_ff);
      endcase
      case (cmd.wr_sel)
         WR_FILL: wr_addr = slot_addr(tb_ff, fill_ff);
         WR_PICK: wr_addr = slot_addr(tb_ff, FW'(p_ff));
         default: wr_addr = slot_addr(tb_ff, cpy_ff);
      endcase
      key_wdata = (cmd.key_src == KEY_REQ) ? key_ff : key_rd_ff;
      ent_wdata = (cmd.ent_src == ENT_REQ) ? ent_ff : ent_rd_ff;
      case (cmd.fill_src)
         FILL_INC: fill_wdata = fill_ff + FW'(1);
         FILL_DEC: fill_wdata = fill_ff - FW'(1);
         default:  fill_wdata = fill_rd_ff;
      endcase
      div_dvd = (cmd.div_sel == DIV_BUCKET) ? bd_ff : ed_ff;
      div_dsr = (cmd.div_sel == DIV_BUCKET) ? DVW'(count_ff) : DVW'(fill_rd_ff);
   end

   always_ff @(posedge clock) begin
      key_rd_ff  <= key_mem[kf_addr];
      fill_rd_ff <= fill_mem[kf_addr];
      ent_rd_ff  <= ent_mem[rd_addr];
      if (cmd.key_wr) begin
         key_mem[tb_ff] <= key_wdata;
      end
      if (cmd.fill_wr) begin
         fill_mem[tb_ff] <= fill_wdata;
      end
      if (cmd.ent_wr) begin
         ent_mem[wr_addr] <= ent_wdata;
      end
   end

   rbol_mod #(.DVW(DVW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.count_clr) begin
         count_in = '0;
      end else if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end
      case (cmd.tb_sel)
         TB_IDX:   tb_in = BW'(idx_ff);
         TB_COUNT: tb_in = BW'(count_ff);
         TB_DIV:   tb_in = BW'(div_rem);
         default:  tb_in = tb_ff;
      endcase
      fill_in = fill_ff;
      if (cmd.fill_zero) begin
         fill_in = '0;
      end else if (cmd.fill_cap) begin
         fill_in = fill_rd_ff;
      end
      cpy_in = cpy_ff;
      if (cmd.cpy_clr) begin
         cpy_in = '0;
      end else if (cmd.cpy_inc) begin
         cpy_in = cpy_ff + FW'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      tb_ff   <= tb_in;
      fill_ff <= fill_in;
      cpy_ff  <= cpy_in;
      if (cmd.load_req) begin
         op_ff  <= req_op;
         key_ff <= KEY_BITS'(req_key);
         ent_ff <= ENTRY_BITS'(req_ent);
         bd_ff  <= req_bdraw;
         ed_ff  <= req_edraw;
      end
      if (cmd.p_ld) begin
         p_ff <= SW'(div_rem);
      end
      if (cmd.got_cap) begin
         got_ff <= ent_rd_ff;
      end
      if (cmd.res_load) begin
         rsp_status_ff <= cmd.res_status;
         rsp_entry_ff  <= (cmd.res_status == ST_REMOVED) ? ENT_W'(got_ff) : '0;
         rsp_empty_ff  <= (count_ff == '0);
         rsp_total_ff  <= TOTAL_W'(count_ff);
      end
   end

   always_comb begin
      stat.op           = op_ff;
      stat.count_zero   = (count_ff == '0);
      stat.count_full   = (count_ff == CW'(MAX_BUCKETS));
      stat.idx_eq_count = (idx_ff == count_ff);
      stat.key_match    = (key_rd_ff == key_ff);
      stat.fill_rd_full = (fill_rd_ff >= FW'(BUCKET_DEPTH));
      stat.div_done     = div_done;
      stat.fill_one     = (fill_ff == FW'(1));
      stat.tb_is_last   = (tb_ff == last);
      stat.copy_done    = (cpy_ff == fill_ff);
      stat.out_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry  = rsp_entry_ff;
   assign rsp_empty  = rsp_empty_ff;
   assign rsp_total  = rsp_total_ff;

endmodule

FILE: hdl/rbol_ctrl.sv
module rbol_ctrl import rbol_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  rbol_stat_type stat,
   output rbol_cmd_type  cmd
);

   rbol_state_type  state_ff, state_in;
   rbol_status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      code_ff <= code_in;
   end

   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      cmd            = '0;
      cmd.res_status = code_ff;
      req_ready      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.op[1]) begin
               cmd.count_clr = 1'b1;
               code_in       = ST_CLEARED;
               state_in      = S_FINISH;
            end else if (stat.op == OP_INSERT) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_SRCH_ADDR;
            end else if (stat.count_zero) begin
               code_in  = ST_EMPTY;
               state_in = S_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_BUCKET;
               state_in      = S_DIV_B;
            end
         end
         S_SRCH_ADDR: begin
            cmd.kf_sel = KF_IDX;
            if (stat.idx_eq_count) begin
               if (stat.count_full) begin
                  code_in  = ST_FULL;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_INS_NEW;
               end
            end else begin
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (stat.key_match) begin
               if (stat.fill_rd_full) begin
                  code_in  = ST_FULL;
                  state_in = S_FINISH;
               end else begin
                  cmd.tb_sel   = TB_IDX;
                  cmd.fill_cap = 1'b1;
                  state_in     = S_INS_WR;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SRCH_ADDR;
            end
         end
         S_INS_NEW: begin
            cmd.tb_sel    = TB_COUNT;
            cmd.fill_zero = 1'b1;
            cmd.count_inc = 1'b1;
            state_in      = S_INS_KEY;
         end
         S_INS_KEY: begin
            cmd.key_wr  = 1'b1;
            cmd.key_src = KEY_REQ;
            state_in    = S_INS_WR;
         end
         S_INS_WR: begin
            cmd.ent_wr   = 1'b1;
            cmd.wr_sel   = WR_FILL;
            cmd.ent_src  = ENT_REQ;
            cmd.fill_wr  = 1'b1;
            cmd.fill_src = FILL_INC;
            code_in      = ST_INSERTED;
            state_in     = S_FINISH;
         end
         S_DIV_B: begin
            cmd.div_sel = DIV_BUCKET;
            if (stat.div_done) begin
               cmd.tb_sel = TB_DIV;
               state_in   = S_RD_FILL;
            end
         end
         S_RD_FILL: begin
            cmd.kf_sel = KF_TB;
            state_in   = S_RD_FILLW;
         end
         S_RD_FILLW: begin
            cmd.kf_sel    = KF_TB;
            cmd.fill_cap  = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_ENTRY;
            state_in      = S_DIV_E;
         end
         S_DIV_E: begin
            cmd.div_sel = DIV_ENTRY;
            if (stat.div_done) begin
               cmd.p_ld = 1'b1;
               state_in = S_PICK_A;
            end
         end
         S_PICK_A: begin
            cmd.rd_sel = RD_PICK;
            state_in   = S_PICK_D;
         end
         S_PICK_D: begin
            cmd.got_cap = 1'b1;
            cmd.rd_sel  = RD_TAIL;
            state_in    = S_TAIL_D;
         end
         S_TAIL_D: begin
            cmd.ent_wr   = 1'b1;
            cmd.wr_sel   = WR_PICK;
            cmd.ent_src  = ENT_RD;
            cmd.fill_wr  = 1'b1;
            cmd.fill_src = FILL_DEC;
            code_in      = ST_REMOVED;
            if (stat.fill_one && stat.tb_is_last) begin
               cmd.count_dec = 1'b1;
               state_in      = S_FINISH;
            end else if (stat.fill_one) begin
               state_in = S_MV_ADDR;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_MV_ADDR: begin
            cmd.kf_sel = KF_LAST;
            state_in   = S_MV_KEY;
         end
         S_MV_KEY: begin
            cmd.kf_sel   = KF_LAST;
            cmd.key_wr   = 1'b1;
            cmd.key_src  = KEY_RD;
            cmd.fill_wr  = 1'b1;
            cmd.fill_src = FILL_RD;
            cmd.fill_cap = 1'b1;
            cmd.cpy_clr  = 1'b1;
            state_in     = S_CP_ADDR;
         end
         S_CP_ADDR: begin
            cmd.rd_sel = RD_COPY;
            if (stat.copy_done) begin
               cmd.count_dec = 1'b1;
               state_in      = S_FINISH;
            end else begin
               state_in = S_CP_WR;
            end
         end
         S_CP_WR: begin
            cmd.ent_wr  = 1'b1;
            cmd.wr_sel  = WR_COPY;
            cmd.ent_src = ENT_RD;
            cmd.cpy_inc = 1'b1;
            cmd.rd_sel  = RD_COPY;
            state_in    = S_CP_ADDR;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/random_bucket_open_list.sv
// Bucketed open list with random removal. Each item carries an opcode in
// req_tuser: insert appends the entry to the bucket holding the same key, or
// opens a new bucket; remove picks bucket_draw modulo the bucket count and then
// entry_draw modulo that bucket's fill, returns that entry and fills its place
// with the bucket's last entry, moving the last bucket into a bucket that runs
// empty; clear empties the list. Every item gives one result item. One item is
// worked on at a time. An insert scans the bucket keys one at a time; a
// store-full result comes for a full bucket and when every bucket is open. A
// remove makes two 16-step remainder passes of the shared divider and, when the
// bucket runs empty, copies the entries of the last bucket one at a time
// through the entry memory. A finished result waits in an output register and
// holds up only the next result. Stores need no clearing pass.
module random_bucket_open_list import rbol_pkg::*; #(
   parameter int MAX_BUCKETS  = 64,
   parameter int BUCKET_DEPTH = 64,
   parameter int KEY_BITS     = 48,
   parameter int ENTRY_BITS   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // key_value[47:0], entry_id[79:48], bucket_draw[95:80], entry_draw[111:96]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // entry_out[31:0], list_empty[32], bucket_total[39:33]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[2:0]
   output logic [STATUS_W-1:0]   rsp_tuser
);

`include "assert_macros.svh"

   rbol_cmd_type        cmd;
   rbol_stat_type       stat;
   logic [ENT_W-1:0]    rsp_entry;
   logic                rsp_empty;
   logic [TOTAL_W-1:0]  rsp_total;

   rbol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rbol_dp #(
      .MAX_BUCKETS  (MAX_BUCKETS),
      .BUCKET_DEPTH (BUCKET_DEPTH),
      .KEY_BITS     (KEY_BITS),
      .ENTRY_BITS   (ENTRY_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (req_tuser),
      .req_key    (req_tdata[47:0]),
      .req_ent    (req_tdata[79:48]),
      .req_bdraw  (req_tdata[95:80]),
      .req_edraw  (req_tdata[111:96]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_entry  (rsp_entry),
      .rsp_empty  (rsp_empty),
      .rsp_total  (rsp_total)
   );

   assign rsp_tdata = {rsp_total, rsp_empty, rsp_entry};

   `ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "accepted while busy")
   `ASSERT_IMPLIES(a_entry_zero, rsp_tvalid && rsp_tuser != ST_REMOVED, rsp_entry == '0, "entry not zero")
   `ASSERT_IMPLIES(a_clear_empty, rsp_tvalid && rsp_tuser == ST_CLEARED, rsp_empty && rsp_total == '0, "clear left buckets")
   `ASSERT_IMPLIES(a_empty_flag, rsp_tvalid && rsp_tuser == ST_EMPTY, rsp_empty, "empty status without flag")

endmodule
